// ----- hw/rtl/stream_find_replace_core_macros.svh -----
// Assertion macros used by the checker of the stream find-and-replace core.
// Depends on nothing; included by the checker file.
`ifndef STREAM_FIND_REPLACE_CORE_MACROS_SVH
`define STREAM_FIND_REPLACE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SFR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfr checker: same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfr checker: next-cycle implication failed");

`endif

// ----- hw/rtl/sfr_pkg.sv -----
// Types and constants of the stream find-and-replace core.
// Used by every RTL file of the block; depends on nothing.
package sfr_pkg;

   // Number of match cells and output queue cells.
   localparam int unsigned CELL_COUNT = 8;
   localparam int unsigned CSR_ADDR_WIDTH = 5;
   localparam int unsigned CSR_DATA_WIDTH = 64;

   typedef enum logic [1:0] {
      CSR_PATTERN_BYTES     = 2'd0,
      CSR_PATTERN_LEN       = 2'd1,
      CSR_REPLACEMENT_BYTES = 2'd2,
      CSR_REPLACEMENT_LEN   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_end;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       end_of_string;
      logic       last_in_run;
   } rsp_payload_type;

   // Load control of one match cell.
   typedef struct packed {
      logic       load;
      logic [7:0] load_byte;
   } match_ctrl_type;

   // Control of one output queue cell.
   typedef struct packed {
      logic load;
      logic shift;
   } queue_ctrl_type;

endpackage

// ----- hw/rtl/stream_find_replace_core.sv -----
// An accepted item's results pass through the output queue cells and then the output register to rsp.
// Throughput: one item per cycle while each item yields at most one result and rsp
// is not stalled; an item that yields several results (up to 8) holds off the next
// item until the 8-cell output queue, which drains one result per pop, is down to its last result.
// Reset: synchronous, clears registers, pending run, queue and output valid.
module stream_find_replace_core #(
   parameter int unsigned PATTERN_MAX     = 8,
   parameter int unsigned REPLACEMENT_MAX = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  sfr_pkg::req_payload_type              req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output sfr_pkg::rsp_payload_type              rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [sfr_pkg::CSR_ADDR_WIDTH-1:0]    paddr,
   input  logic [sfr_pkg::CSR_DATA_WIDTH-1:0]    pwdata,
   output logic [sfr_pkg::CSR_DATA_WIDTH-1:0]    prdata,
   output logic                                  pready
);

   localparam int unsigned PatLim = (PATTERN_MAX < 8) ? PATTERN_MAX : 8;
   localparam int unsigned RepLim = (REPLACEMENT_MAX < 8) ? REPLACEMENT_MAX : 8;
   localparam int unsigned Cells  = sfr_pkg::CELL_COUNT;

   logic [63:0] pattern_bytes_ff;
   logic [3:0]  pattern_len_ff;
   logic [63:0] replacement_bytes_ff;
   logic [3:0]  replacement_len_ff;

   logic [2:0]  pcnt_ff;
   logic [2:0]  pcnt_in;
   logic [3:0]  qcnt_ff;
   logic [3:0]  qcnt_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   sfr_pkg::rsp_payload_type rsp_data_ff;
   sfr_pkg::rsp_payload_type rsp_data_in;

   logic        accept;
   logic        pop;
   logic        csr_write;
   sfr_pkg::csr_index_type csr_index;

   logic [3:0]  n;
   logic [3:0]  plen;
   logic [3:0]  rlen;
   logic        full;
   logic [3:0]  cut;
   logic [3:0]  new_cnt;

   logic [7:0]  buf_w [Cells];
   logic [7:0]  eq_w [Cells];
   sfr_pkg::match_ctrl_type  mctrl [Cells];
   sfr_pkg::rsp_payload_type new_item [Cells];
   sfr_pkg::rsp_payload_type q_item [Cells];
   sfr_pkg::rsp_payload_type q_next [Cells];
   sfr_pkg::queue_ctrl_type  qctrl;

   // Configuration port: writes complete in the access phase.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = sfr_pkg::csr_index_type'(paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff     <= '0;
         pattern_len_ff       <= '0;
         replacement_bytes_ff <= '0;
         replacement_len_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            sfr_pkg::CSR_PATTERN_BYTES:     pattern_bytes_ff     <= pwdata;
            sfr_pkg::CSR_PATTERN_LEN:       pattern_len_ff       <= pwdata[3:0];
            sfr_pkg::CSR_REPLACEMENT_BYTES: replacement_bytes_ff <= pwdata;
            sfr_pkg::CSR_REPLACEMENT_LEN:   replacement_len_ff   <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      case (csr_index)
         sfr_pkg::CSR_PATTERN_BYTES:     prdata = pattern_bytes_ff;
         sfr_pkg::CSR_PATTERN_LEN:       prdata = {60'd0, pattern_len_ff};
         sfr_pkg::CSR_REPLACEMENT_BYTES: prdata = replacement_bytes_ff;
         sfr_pkg::CSR_REPLACEMENT_LEN:   prdata = {60'd0, replacement_len_ff};
         default:                        prdata = '0;
      endcase
   end

   // Lengths saturate at the configured bounds.
   assign plen = (pattern_len_ff > 4'(PatLim)) ? 4'(PatLim) : pattern_len_ff;
   assign rlen = (replacement_len_ff > 4'(RepLim)) ? 4'(RepLim) : replacement_len_ff;

   // Candidate run is the pending bytes plus the incoming byte.
   assign n = {1'b0, pcnt_ff} + 4'd1;

   // Row of match cells.
   for (genvar j = 0; j < Cells; j++) begin : g_match
      sfr_match_cell u_cell (
         .clock      (clock),
         .ctrl       (mctrl[j]),
         .take_input (3'(j) == pcnt_ff),
         .in_byte    (req_data.in_byte),
         .pattern    (pattern_bytes_ff),
         .cur_byte   (buf_w[j]),
         .eq         (eq_w[j])
      );
   end

   // Full match and the first shift that leaves a proper pattern prefix.
   always_comb begin
      logic ok;
      full = (n == plen);
      for (int k = 0; k < 8; k++) begin
         if ((4'(k) < n) && !eq_w[k][k]) begin
            full = 1'b0;
         end
      end
      cut = n;
      for (int s = 7; s >= 0; s--) begin
         ok = (4'(s) < n) && ((n - 4'(s)) < plen);
         for (int i = 0; i < 8 - s; i++) begin
            if ((4'(i) < (n - 4'(s))) && !eq_w[s+i][i]) begin
               ok = 1'b0;
            end
         end
         if (ok) begin
            cut = 4'(s);
         end
      end
   end

   // Burst of result items caused by the incoming item.
   always_comb begin
      if (full) begin
         new_cnt = rlen;
      end else if (req_data.string_end) begin
         new_cnt = n;
      end else begin
         new_cnt = cut;
      end
      for (int k = 0; k < 8; k++) begin
         new_item[k].out_byte      = full ? replacement_bytes_ff[8*k +: 8] : buf_w[k];
         new_item[k].has_byte      = 1'b1;
         new_item[k].end_of_string = 1'b0;
         new_item[k].last_in_run   = 1'b0;
      end
      // An end of string with nothing to emit becomes a marker item.
      if (req_data.string_end && (new_cnt == 4'd0)) begin
         new_cnt             = 4'd1;
         new_item[0].out_byte = 8'h00;
         new_item[0].has_byte = 1'b0;
      end
      for (int k = 0; k < 8; k++) begin
         if (4'(k) == (new_cnt - 4'd1)) begin
            new_item[k].last_in_run   = 1'b1;
            new_item[k].end_of_string = req_data.string_end;
         end
      end
   end

   // Pending run update: the match cells take the bytes after the cut.
   always_comb begin
      logic [4:0] idx;
      for (int j = 0; j < 8; j++) begin
         idx = {1'b0, cut} + 5'(j);
         mctrl[j].load       = accept;
         mctrl[j].load_byte  = (idx < 5'd8) ? buf_w[idx[2:0]] : 8'h00;
      end
   end

   assign pcnt_in = !accept ? pcnt_ff :
                    (full || req_data.string_end) ? 3'd0 : 3'(n - cut);

   // Output queue handshake.
   assign pop       = (qcnt_ff != 4'd0) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (qcnt_ff == 4'd0) || ((qcnt_ff == 4'd1) && pop);
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (accept) begin
         qcnt_in = new_cnt;
      end else if (pop) begin
         qcnt_in = qcnt_ff - 4'd1;
      end else begin
         qcnt_in = qcnt_ff;
      end
   end

   assign qctrl.load  = accept;
   assign qctrl.shift = pop;

   // Row of queue cells; each shifts toward cell zero on a pop.
   for (genvar j = 0; j < Cells; j++) begin : g_queue
      if (j == Cells - 1) begin : g_tail
         assign q_next[j] = '0;
      end else begin : g_body
         assign q_next[j] = q_item[j+1];
      end
      sfr_queue_cell u_cell (
         .clock      (clock),
         .ctrl       (qctrl),
         .load_item  (new_item[j]),
         .shift_item (q_next[j]),
         .item       (q_item[j])
      );
   end

   // Output register fed from the head of the queue.
   assign rsp_valid_in = pop ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in  = pop ? q_item[0] : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pcnt_ff      <= '0;
         qcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pcnt_ff      <= pcnt_in;
         qcnt_ff      <= qcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/sfr_match_cell.sv -----
// One match cell: holds a pending byte and compares the byte at its position
// against every pattern byte. Depends on sfr_pkg.
module sfr_match_cell (
   input  logic                  clock,
   input  sfr_pkg::match_ctrl_type ctrl,
   input  logic                  take_input,
   input  logic [7:0]            in_byte,
   input  logic [63:0]           pattern,
   output logic [7:0]            cur_byte,
   output logic [7:0]            eq
);

   logic [7:0] pend_ff;
   logic [7:0] pend_in;

   // The pending byte is replaced only when an item is accepted.
   assign pend_in = ctrl.load ? ctrl.load_byte : pend_ff;

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

   // The cell just past the pending run shows the incoming byte.
   assign cur_byte = take_input ? in_byte : pend_ff;

   // Compare against each pattern byte.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         eq[i] = (cur_byte == pattern[8*i +: 8]);
      end
   end

endmodule

// ----- hw/rtl/sfr_queue_cell.sv -----
// One output queue cell: holds one result item and hands it toward the head.
// Depends on sfr_pkg.
module sfr_queue_cell (
   input  logic                     clock,
   input  sfr_pkg::queue_ctrl_type  ctrl,
   input  sfr_pkg::rsp_payload_type load_item,
   input  sfr_pkg::rsp_payload_type shift_item,
   output sfr_pkg::rsp_payload_type item
);

   sfr_pkg::rsp_payload_type item_ff;
   sfr_pkg::rsp_payload_type item_in;

   // A new burst overrides the shift from the neighbor.
   always_comb begin
      if (ctrl.load) begin
         item_in = load_item;
      end else if (ctrl.shift) begin
         item_in = shift_item;
      end else begin
         item_in = item_ff;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item = item_ff;

endmodule

// ----- hw/rtl/sfr_checker.sv -----
// Port-level checks of the stream find-and-replace core, bound to the top level.
// Depends on sfr_pkg and stream_find_replace_core_macros.svh.
`include "stream_find_replace_core_macros.svh"

module sfr_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input sfr_pkg::rsp_payload_type rsp_data
);

   // A stalled result item holds its payload.
   `SFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // A marker item closes the string and carries a zero byte.
   `SFR_ASSERT_IMPLY(a_marker_form, clock, reset, rsp_valid && !rsp_data.has_byte, rsp_data.end_of_string && rsp_data.last_in_run && (rsp_data.out_byte == 8'h00))

   // The end of the string is always the last item of its run.
   `SFR_ASSERT_IMPLY(a_eos_last, clock, reset, rsp_valid && rsp_data.end_of_string, rsp_data.last_in_run)

endmodule

bind stream_find_replace_core sfr_checker u_sfr_checker (.*);

// ----- dv/tb_stream_find_replace_core.sv -----
// Testbench for the stream find-and-replace core: directed strings, then random streams.
// Depends on sfr_pkg and stream_find_replace_core; predicts every result item in SystemVerilog.
`timescale 1ns / 1ps

module tb_stream_find_replace_core;

   localparam int unsigned PATTERN_LIMIT     = 8;
   localparam int unsigned REPLACEMENT_LIMIT = 8;
   localparam int unsigned SETTLE_CYCLES     = 4;

   logic                                       clock = 1'b0;
   logic                                       reset = 1'b1;
   logic                                       req_valid = 1'b0;
   logic                                       req_ready;
   sfr_pkg::req_payload_type                   req_data = '0;
   logic                                       rsp_valid;
   logic                                       rsp_ready = 1'b0;
   sfr_pkg::rsp_payload_type                   rsp_data;
   logic                                       psel = 1'b0;
   logic                                       penable = 1'b0;
   logic                                       pwrite = 1'b0;
   logic [sfr_pkg::CSR_ADDR_WIDTH-1:0]         paddr = '0;
   logic [sfr_pkg::CSR_DATA_WIDTH-1:0]         pwdata = '0;
   logic [sfr_pkg::CSR_DATA_WIDTH-1:0]         prdata;
   logic                                       pready;

   // Shadow copy of the registers and of the held match run.
   logic [63:0]                       cfg_pattern = '0;
   logic [3:0]                        cfg_pattern_len = '0;
   logic [63:0]                       cfg_repl = '0;
   logic [3:0]                        cfg_repl_len = '0;
   logic [7:0]                        held_bytes [7];
   int unsigned                       held_count = 0;

   sfr_pkg::rsp_payload_type          expected_bytes [$];
   int unsigned                       fail_count = 0;
   int unsigned                       req_idle_pct = 14;
   int unsigned                       rsp_idle_pct = 14;

   stream_find_replace_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // Clock with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

   task automatic log_failure(string msg);
      if (fail_count < 10) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
      fail_count++;
   endtask

   // Works out the result items of one input byte and queues them in order.
   function automatic void predict_replace(logic [7:0] in_byte, logic string_end);
      logic [7:0]      run [8];
      int unsigned     n, plen, rlen, s, i;
      bit              matched, prefix;
      sfr_pkg::rsp_payload_type item;
      sfr_pkg::rsp_payload_type produced [$];
      plen = (cfg_pattern_len > PATTERN_LIMIT) ? PATTERN_LIMIT : cfg_pattern_len;
      rlen = (cfg_repl_len > REPLACEMENT_LIMIT) ? REPLACEMENT_LIMIT : cfg_repl_len;
      n = held_count;
      for (i = 0; i < n; i++) run[i] = held_bytes[i];
      run[n] = in_byte;
      n++;

      // A full match needs the whole run to equal the pattern.
      matched = (n == plen);
      for (i = 0; matched && i < n; i++) begin
         if (run[i] !== cfg_pattern[8*i +: 8]) matched = 1'b0;
      end

      if (matched) begin
         for (i = 0; i < rlen; i++) begin
            item = '{out_byte: cfg_repl[8*i +: 8], has_byte: 1'b1,
                     end_of_string: 1'b0, last_in_run: 1'b0};
            produced.push_back(item);
         end
         held_count = 0;
      end else begin
         // Drop front bytes until the rest is a proper prefix of the pattern.
         for (s = 0; s < n; s++) begin
            prefix = (n - s) < plen;
            for (i = 0; prefix && i < n - s; i++) begin
               if (run[s+i] !== cfg_pattern[8*i +: 8]) prefix = 1'b0;
            end
            if (prefix) break;
         end
         for (i = 0; i < s; i++) begin
            item = '{out_byte: run[i], has_byte: 1'b1, end_of_string: 1'b0, last_in_run: 1'b0};
            produced.push_back(item);
         end
         if (string_end) begin
            for (i = s; i < n; i++) begin
               item = '{out_byte: run[i], has_byte: 1'b1,
                        end_of_string: 1'b0, last_in_run: 1'b0};
               produced.push_back(item);
            end
            held_count = 0;
         end else begin
            held_count = n - s;
            for (i = 0; i < held_count; i++) held_bytes[i] = run[s+i];
         end
      end

      // The end of the string rides on the last item, or on a bare marker.
      if (string_end) begin
         held_count = 0;
         if (produced.size() == 0) begin
            item = '{out_byte: 8'h00, has_byte: 1'b0, end_of_string: 1'b1, last_in_run: 1'b0};
            produced.push_back(item);
         end else begin
            produced[produced.size()-1].end_of_string = 1'b1;
         end
      end
      if (produced.size() > 0) produced[produced.size()-1].last_in_run = 1'b1;
      foreach (produced[j]) expected_bytes.push_back(produced[j]);
   endfunction

   // Result side: random back-pressure, changed at the falling edge.
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= rsp_idle_pct);
   end

   // Result side: compare every accepted item with the oldest expectation.
   always @(posedge clock) begin
      sfr_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            log_failure($sformatf("unexpected item byte=%02h has=%b eos=%b last=%b",
               rsp_data.out_byte, rsp_data.has_byte, rsp_data.end_of_string,
               rsp_data.last_in_run));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_data.out_byte !== want.out_byte || rsp_data.has_byte !== want.has_byte ||
                rsp_data.end_of_string !== want.end_of_string ||
                rsp_data.last_in_run !== want.last_in_run) begin
               log_failure($sformatf(
                  "expected byte=%02h has=%b eos=%b last=%b, got byte=%02h has=%b eos=%b last=%b",
                  want.out_byte, want.has_byte, want.end_of_string, want.last_in_run,
                  rsp_data.out_byte, rsp_data.has_byte, rsp_data.end_of_string,
                  rsp_data.last_in_run));
            end
         end
      end
   end

   // Sends one byte; returns at the falling edge after it was accepted, valid still high.
   task automatic send_byte(logic [7:0] value, logic string_end);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = '{in_byte: value, string_end: string_end};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_replace(value, string_end);
      @(negedge clock);
   endtask

   task automatic send_text(string text, bit end_on_last);
      for (int i = 0; i < text.len(); i++) begin
         send_byte(text[i], end_on_last && (i == text.len() - 1));
      end
   endtask

   // Holds the sender until every expected item has come and the block has settled.
   task automatic wait_drain();
      req_valid = 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [63:0] pack_text(string text);
      logic [63:0] word;
      word = '0;
      for (int i = 0; i < text.len() && i < 8; i++) word[8*i +: 8] = text[i];
      return word;
   endfunction

   // Writes one register while idle, then reads it back.
   task automatic write_register(sfr_pkg::csr_index_type index, logic [63:0] value);
      logic [63:0] mask;
      logic [63:0] got;
      wait_drain();
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {index, 3'b000};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (index)
         sfr_pkg::CSR_PATTERN_BYTES:     cfg_pattern = value;
         sfr_pkg::CSR_PATTERN_LEN:       cfg_pattern_len = value[3:0];
         sfr_pkg::CSR_REPLACEMENT_BYTES: cfg_repl = value;
         sfr_pkg::CSR_REPLACEMENT_LEN:   cfg_repl_len = value[3:0];
         default: ;
      endcase
      mask = (index == sfr_pkg::CSR_PATTERN_LEN || index == sfr_pkg::CSR_REPLACEMENT_LEN) ?
             64'hF : '1;
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      got = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      if ((got & mask) !== (value & mask)) begin
         log_failure($sformatf("register %s read %016h, expected %016h",
            index.name(), got & mask, value & mask));
      end
   endtask

   task automatic configure(logic [63:0] pattern, logic [3:0] plen,
                            logic [63:0] repl, logic [3:0] rlen);
      write_register(sfr_pkg::CSR_PATTERN_BYTES, pattern);
      write_register(sfr_pkg::CSR_PATTERN_LEN, {60'd0, plen});
      write_register(sfr_pkg::CSR_REPLACEMENT_BYTES, repl);
      write_register(sfr_pkg::CSR_REPLACEMENT_LEN, {60'd0, rlen});
   endtask

   // Zero pattern length: bytes pass through, extremes of the byte range included.
   task automatic test_pass_through();
      configure(pack_text("ab"), 4'd0, pack_text("XY"), 4'd2);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b1);
   endtask

   // A match deleted at the end of the string leaves only the end marker.
   task automatic test_end_marker();
      configure(pack_text("ab"), 4'd2, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
      send_text("ab", 1'b1);
   endtask

   // Replacement with partial mismatches and a pending flush at the end.
   task automatic test_match_replace();
      configure(pack_text("abc"), 4'd3, pack_text("WXYZ"), 4'd4);
      send_text("aabcabx", 1'b1);
   endtask

   // Lengths above the limit saturate; full-size pattern and replacement.
   task automatic test_length_saturation();
      configure(pack_text("qrstuvwx"), 4'd15, pack_text("01234567"), 4'd15);
      send_text("qrstuvwx", 1'b1);
   endtask

   // Pending bytes survive a pattern change inside a string.
   task automatic test_config_mid_string();
      configure(pack_text("abc"), 4'd3, pack_text("R"), 4'd1);
      send_text("ab", 1'b0);
      configure(pack_text("bd"), 4'd2, pack_text("S"), 4'd1);
      send_text("d", 1'b1);
   endtask

   // Random streams over a small alphabet, rich in whole and broken patterns.
   task automatic test_random_streams();
      logic [7:0]  letters [3];
      logic [63:0] pattern;
      logic [3:0]  plen, rlen;
      int unsigned eff_len, part, sent, pick;
      bit          drained;
      drained = 1'b0;
      for (int phase = 0; phase < 12; phase++) begin
         foreach (letters[k]) letters[k] = 8'($urandom_range(255));
         case (phase)
            0: begin plen = 4'd8; rlen = 4'd8; end
            1: begin plen = 4'd15; rlen = 4'd0; end
            2: begin plen = 4'd1; rlen = 4'd1; end
            default: begin
               plen = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) :
                                                 4'($urandom_range(1, 8));
               rlen = 4'($urandom_range(15));
            end
         endcase
         eff_len = (plen > PATTERN_LIMIT) ? PATTERN_LIMIT : plen;
         pattern = {$urandom, $urandom};
         for (int k = 0; k < eff_len; k++) begin
            pattern[8*k +: 8] = letters[2'($urandom_range(2))];
         end
         configure(pattern, plen, {$urandom, $urandom}, rlen);

         // One phase runs with no idling on either side.
         req_idle_pct = (phase == 6) ? 0 : 14;
         rsp_idle_pct = (phase == 6) ? 0 : 14;

         sent = 0;
         while (sent < 31) begin
            pick = $urandom_range(99);
            if (pick < 40 && eff_len > 0) begin
               part = ($urandom_range(9) < 7) ? eff_len : $urandom_range(1, eff_len);
               for (int k = 0; k < part; k++) begin
                  send_byte(pattern[8*k +: 8], $urandom_range(14) == 0);
                  sent++;
               end
            end else if (pick < 88) begin
               send_byte(letters[2'($urandom_range(2))], $urandom_range(14) == 0);
               sent++;
            end else begin
               send_byte(8'($urandom_range(255)), $urandom_range(14) == 0);
               sent++;
            end
            // Once, the sender holds off until everything has come back.
            if (phase == 3 && sent >= 17 && !drained) begin
               wait_drain();
               drained = 1'b1;
            end
         end
      end
      req_idle_pct = 14;
      rsp_idle_pct = 14;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_pass_through();
      test_end_marker();
      test_match_replace();
      test_length_saturation();
      test_config_mid_string();
      test_random_streams();

      wait_drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_bytes.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
